// File: rtl/htsd_pkg.sv
// package for the huffman tree stream decoder
// holds phases, error codes, node layout, default sizes and the result record; no dependencies
`default_nettype none
package htsd_pkg;
  localparam int NodeSlotsDef  = 512;
  localparam int StackSlotsDef = 256;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_TREE   = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_DRAIN  = 2'd3;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_TREE   = 2'd1;
  localparam logic [1:0] ERR_ENDED  = 2'd2;
  localparam logic [1:0] ERR_HEADER = 2'd3;

  localparam int LeafBit = 18;
  localparam int NodeW   = 19;

  typedef struct packed {
    logic [7:0] symbol;
    logic       symbol_valid;
    logic       last_in_run;
    logic       end_of_stream;
    logic [1:0] error_code;
  } result_t;
endpackage
`default_nettype wire

// File: rtl/huffman_tree_stream_decoder.sv
// top level of the huffman tree stream decoder
// depends on htsd_pkg; holds the node table, build stack and bit sequencer
`default_nettype none
// One compressed byte is requested at a time and handled bit by bit by a small
// sequencer around a single node table port with registered read data. A header
// byte is checked and taken in the idle state. A tree byte takes one pass per
// bit, plus one more whenever a new node completes its parent's right side (the
// parent entry is written then), plus one pass to see the byte end. A data byte
// first reads the root, then for each data bit reads the current node, reads the
// chosen child and checks it for a leaf, and ends with a pass to see the byte
// end. Every symbol result and the closing result take a state of their own,
// each stretched for as long as the output register is stalled. A decoded symbol
// is held back until the next one or the byte end, so the last result of a
// byte can carry last_in_run. Input stall is high whenever the sequencer is not
// idle; results leave through one output register. The final byte always
// produces a closing result with end_of_stream set and the latched error code;
// the decoder is then ready for a new stream. Node table and stack need no
// clearing after reset: the top of the build stack lives in a register and a
// completed tree never reads an unwritten node entry.
module huffman_tree_stream_decoder #(
  parameter int NODE_SLOTS  = htsd_pkg::NodeSlotsDef,
  parameter int STACK_SLOTS = htsd_pkg::StackSlotsDef
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic [7:0] out_symbol,
  output      logic       out_symbol_valid,
  output      logic       out_last_in_run,
  output      logic       out_end_of_stream,
  output      logic [1:0] out_error_code
);
  import htsd_pkg::*;

  localparam int NW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int SW = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
  localparam int NCW = $clog2(NODE_SLOTS + 1);
  localparam int STW = $clog2(STACK_SLOTS + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BIT   = 3'd1;  // pick next bit, issue read or write
  localparam logic [2:0] S_WAIT  = 3'd2;  // current node read back
  localparam logic [2:0] S_CHILD = 3'd3;  // child entry back, or parent link write
  localparam logic [2:0] S_EMIT  = 3'd4;  // held symbol goes out, new one held
  localparam logic [2:0] S_CLOSE = 3'd5;  // closing result
  localparam logic [2:0] S_ROOT  = 3'd6;  // root read back at start of byte
  localparam logic [2:0] S_FLUSH = 3'd7;  // held symbol goes out at byte end

  logic [2:0]  st_r, st_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  lvb_r, lvb_nxt;
  logic [NCW-1:0] ncount_r, ncount_nxt;
  logic [STW-1:0] stop_r, stop_nxt;
  logic [7:0]  lsym_r, lsym_nxt;
  logic [3:0]  lleft_r, lleft_nxt;
  logic [NW-1:0] walk_r, walk_nxt;  // walk position, or parent while building
  logic [1:0]  err_r, err_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic [3:0]  bidx_r, bidx_nxt;   // bits consumed of this byte
  logic [3:0]  blim_r, blim_nxt;
  logic        pend_r, pend_nxt;   // a decoded symbol is held in esym_r
  logic [7:0]  esym_r, esym_nxt;
  logic        reload_r, reload_nxt;  // stack top comes back from the stack read

  // node table: one port, registered read
  logic [NodeW-1:0] node_mem [NODE_SLOTS];
  logic [NodeW-1:0] nrd_r;
  logic             nwe;
  logic [NW-1:0]    naddr;
  logic [NodeW-1:0] nwdata;
  logic             nre;

  // build stack: entries below the top, top entry kept in stkc_r
  logic [NW:0]   stk_mem [STACK_SLOTS];
  logic          swe;
  logic [SW-1:0] swaddr;
  logic [NW:0]   swdata;
  logic          sre;
  logic [SW-1:0] sraddr;
  logic [NW:0]   srd_r;

  logic [NW:0] stkc_r, stkc_nxt;

  always_ff @(posedge clk) begin
    if (nwe) node_mem[naddr] <= nwdata;
    if (nre) nrd_r <= node_mem[naddr];
    if (swe) stk_mem[swaddr] <= swdata;
    if (sre) srd_r <= stk_mem[sraddr];
  end

  // output register
  result_t res_r, res_nxt;
  logic    ov_r, ov_nxt;
  logic    out_free;
  assign out_free = !ov_r || !out_stall;

  logic in_acc;
  assign in_stall = (st_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  logic cur_bit;
  assign cur_bit = byte_r[3'd7 - bidx_r[2:0]];

  logic [NW-1:0] child;
  assign child = cur_bit ? nrd_r[NW-1:0] : nrd_r[9+NW-1:9];

  always_comb begin
    logic          addn, leaf, big, done, rlink;
    logic [7:0]    sym;
    logic [NW-1:0] n, p;
    logic [STW-1:0] sp;
    addn = 1'b0; leaf = 1'b0; big = 1'b0; done = 1'b0; rlink = 1'b0;
    sym = '0; n = '0; p = '0; sp = '0;
    st_nxt = st_r; phase_nxt = phase_r; lvb_nxt = lvb_r; ncount_nxt = ncount_r;
    stop_nxt = stop_r; lsym_nxt = lsym_r; lleft_nxt = lleft_r; walk_nxt = walk_r;
    err_nxt = err_r; byte_nxt = byte_r; last_nxt = last_r; bidx_nxt = bidx_r;
    blim_nxt = blim_r; pend_nxt = pend_r; esym_nxt = esym_r;
    reload_nxt = reload_r; stkc_nxt = stkc_r;
    res_nxt = res_r; ov_nxt = ov_r && out_stall;
    nwe = 1'b0; nre = 1'b0; naddr = '0; nwdata = '0;
    swe = 1'b0; swaddr = '0; swdata = '0;
    sre = 1'b0; sraddr = '0;

    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          byte_nxt = in_data_byte; last_nxt = in_last_byte;
          bidx_nxt = '0;
          unique case (phase_r)
            PH_HEADER: begin
              if (in_data_byte < 8'd1 || in_data_byte > 8'd8) begin
                err_nxt = ERR_HEADER; phase_nxt = PH_DRAIN;
              end else begin
                lvb_nxt = in_data_byte[3:0]; ncount_nxt = '0; stop_nxt = '0;
                lleft_nxt = '0; lsym_nxt = '0; phase_nxt = PH_TREE;
                if (in_last_byte) err_nxt = ERR_ENDED;
              end
              st_nxt = in_last_byte ? S_CLOSE : S_IDLE;
            end
            PH_TREE: begin
              blim_nxt = 4'd8; st_nxt = S_BIT;
            end
            PH_DATA: begin
              blim_nxt = in_last_byte ? lvb_r : 4'd8;
              naddr = '0; nre = 1'b1; st_nxt = S_ROOT;
            end
            default: st_nxt = in_last_byte ? S_CLOSE : S_IDLE;
          endcase
        end
      end
      S_ROOT: begin
        // one-leaf tree consumes data silently
        if (nrd_r[LeafBit]) st_nxt = last_r ? S_CLOSE : S_IDLE;
        else st_nxt = S_BIT;
      end
      S_BIT: begin
        if (bidx_r >= blim_r) begin
          if (phase_r == PH_TREE && last_r) err_nxt = ERR_ENDED;
          if (phase_r == PH_DATA && pend_r) st_nxt = S_FLUSH;
          else st_nxt = last_r ? S_CLOSE : S_IDLE;
        end else if (phase_r == PH_DATA) begin
          naddr = walk_r; nre = 1'b1; st_nxt = S_WAIT;
        end else begin
          // tree building, one bit per pass
          sym = {lsym_r[6:0], cur_bit};
          sp = stop_r; p = stkc_r[NW-1:0]; n = ncount_r[NW-1:0];
          bidx_nxt = bidx_r + 4'd1;
          st_nxt = S_BIT;
          if (lleft_r != 4'd0) begin
            lsym_nxt = sym; lleft_nxt = lleft_r - 4'd1;
            if (lleft_r == 4'd1) begin addn = 1'b1; leaf = 1'b1; end
          end else if (cur_bit) begin
            lleft_nxt = 4'd8; lsym_nxt = '0;
          end else addn = 1'b1;
          if (addn) begin
            if (ncount_r >= NCW'(NODE_SLOTS)) big = 1'b1;
            else begin
              ncount_nxt = ncount_r + 1'b1;
              nwe = 1'b1; naddr = n;
              nwdata = leaf ? {1'b1, 10'd0, sym} : '0;
              if (stop_r != '0) begin
                if (!stkc_r[NW]) begin
                  // left side of the open parent
                  stkc_nxt = {1'b1, p};
                end else begin
                  // right side: parent is written next cycle and popped
                  rlink = 1'b1; sp = stop_r - 1'b1;
                  walk_nxt = p; st_nxt = S_CHILD;
                  if (leaf && sp != '0) begin
                    sre = 1'b1; sraddr = SW'(sp - 1'b1); reload_nxt = 1'b1;
                  end
                end
              end
              if (!leaf) begin
                if (sp >= STW'(STACK_SLOTS)) big = 1'b1;
                else begin
                  // old top goes below the new one
                  if (!rlink && stop_r != '0) begin
                    swe = 1'b1; swaddr = SW'(stop_r - 1'b1); swdata = {1'b1, p};
                  end
                  stkc_nxt = {1'b0, n}; sp = sp + 1'b1;
                end
              end else if (!rlink && sp == '0) done = 1'b1;
              stop_nxt = sp;
            end
          end
          if (big) begin
            err_nxt = ERR_TREE; phase_nxt = PH_DRAIN;
            st_nxt = last_r ? S_CLOSE : S_IDLE;
          end else if (done) begin
            phase_nxt = PH_DATA; walk_nxt = '0;
            st_nxt = last_r ? S_CLOSE : S_IDLE;
          end
        end
      end
      S_CHILD: begin
        if (phase_r == PH_TREE) begin
          // parent walk_r: left child follows it in preorder, right is the new node
          n = NW'(ncount_r - 1'b1);
          naddr = walk_r; nwe = 1'b1;
          nwdata = '0;
          nwdata[9+NW-1:9] = walk_r + NW'(1);
          nwdata[NW-1:0] = n;
          if (reload_r) stkc_nxt = srd_r;
          reload_nxt = 1'b0;
          if (stop_r == '0) begin
            phase_nxt = PH_DATA; walk_nxt = '0;
            st_nxt = last_r ? S_CLOSE : S_IDLE;
          end else st_nxt = S_BIT;
        end else begin
          // data walk: nrd_r holds child entry
          bidx_nxt = bidx_r + 4'd1;
          if (nrd_r[LeafBit]) begin
            walk_nxt = '0;
            if (pend_r) st_nxt = S_EMIT;
            else begin
              pend_nxt = 1'b1; esym_nxt = nrd_r[7:0]; st_nxt = S_BIT;
            end
          end else st_nxt = S_BIT;
        end
      end
      S_WAIT: begin
        walk_nxt = child; naddr = child; nre = 1'b1; st_nxt = S_CHILD;
      end
      S_EMIT: begin
        // a newer symbol exists, so the held one is not last of the byte
        if (out_free) begin
          ov_nxt = 1'b1;
          res_nxt.symbol = esym_r; res_nxt.symbol_valid = 1'b1;
          res_nxt.end_of_stream = 1'b0; res_nxt.error_code = ERR_NONE;
          res_nxt.last_in_run = 1'b0;
          esym_nxt = nrd_r[7:0];
          st_nxt = S_BIT;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          ov_nxt = 1'b1; pend_nxt = 1'b0;
          res_nxt.symbol = esym_r; res_nxt.symbol_valid = 1'b1;
          res_nxt.end_of_stream = 1'b0; res_nxt.error_code = ERR_NONE;
          res_nxt.last_in_run = !last_r;
          st_nxt = last_r ? S_CLOSE : S_IDLE;
        end
      end
      S_CLOSE: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          res_nxt.symbol = '0; res_nxt.symbol_valid = 1'b0;
          res_nxt.end_of_stream = 1'b1; res_nxt.error_code = err_r;
          res_nxt.last_in_run = 1'b1;
          phase_nxt = PH_HEADER; lvb_nxt = '0; ncount_nxt = '0; stop_nxt = '0;
          lsym_nxt = '0; lleft_nxt = '0; walk_nxt = '0; err_nxt = ERR_NONE;
          pend_nxt = 1'b0; reload_nxt = 1'b0;
          st_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; phase_r <= PH_HEADER; lvb_r <= '0; ncount_r <= '0;
      stop_r <= '0; lsym_r <= '0; lleft_r <= '0; walk_r <= '0; err_r <= ERR_NONE;
      ov_r <= 1'b0; pend_r <= 1'b0; reload_r <= 1'b0; bidx_r <= '0; blim_r <= '0;
      last_r <= 1'b0;
    end else begin
      st_r <= st_nxt; phase_r <= phase_nxt; lvb_r <= lvb_nxt;
      ncount_r <= ncount_nxt; stop_r <= stop_nxt; lsym_r <= lsym_nxt;
      lleft_r <= lleft_nxt; walk_r <= walk_nxt; err_r <= err_nxt; ov_r <= ov_nxt;
      pend_r <= pend_nxt; reload_r <= reload_nxt; bidx_r <= bidx_nxt;
      blim_r <= blim_nxt; last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt; esym_r <= esym_nxt; res_r <= res_nxt; stkc_r <= stkc_nxt;
  end

  assign out_valid         = ov_r;
  assign out_symbol        = res_r.symbol;
  assign out_symbol_valid  = res_r.symbol_valid;
  assign out_last_in_run   = res_r.last_in_run;
  assign out_end_of_stream = res_r.end_of_stream;
  assign out_error_code    = res_r.error_code;
endmodule
`default_nettype wire
